### rtl/bfa_pkg.sv
// Shared constants, types and helper functions of the bitmap frame allocator.
// No dependencies; imported by every module of the block.
package bfa_pkg;

    localparam int NUM_FRAMES    = 65536;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_DEPTH     = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_AW       = $clog2(MAP_DEPTH);
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int REG_W         = 17;
    localparam int FRAME_W       = 16;
    localparam int HI_W          = REG_W - BIT_W;
    localparam int CFG_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int LOW_RES_RESET = 256;

    // register select bit of paddr
    localparam logic CFG_IDX_LIMIT  = 1'b0;
    localparam logic CFG_IDX_LOWRES = 1'b1;

    typedef logic [MAP_WORD_BITS-1:0] t_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_RMW,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        REQ_ALLOC,
        REQ_FREE,
        REQ_RESERVE,
        REQ_NONE
    } t_req;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOMEM,
        ST_RANGE,
        ST_DOUBLE
    } t_status;

    // Bits of map word w whose frame index is >= x.
    function automatic t_word word_ge_mask(input logic [REG_W-1:0] x,
                                           input logic [WORD_AW-1:0] w);
        logic [HI_W-1:0] xh;
        logic [HI_W-1:0] wh;
        t_word           m;
        xh = x[REG_W-1:BIT_W];
        wh = HI_W'(w);
        if (xh < wh) begin
            m = {MAP_WORD_BITS{1'b1}};
        end else if (xh == wh) begin
            m = {MAP_WORD_BITS{1'b1}} << x[BIT_W-1:0];
        end else begin
            m = '0;
        end
        return m;
    endfunction

    // Position of the lowest set bit (0 when none is set).
    function automatic logic [BIT_W-1:0] low_index(input t_word v);
        t_word            iso;
        logic [BIT_W-1:0] idx;
        iso = v & (~v + t_word'(1));
        idx = '0;
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            if (iso[b]) begin
                idx = idx | BIT_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/bfa_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on bfa_pkg.
module bfa_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bfa_pkg::REG_W-1:0] i_dividend,
    input  logic [bfa_pkg::REG_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [bfa_pkg::REG_W-1:0] o_rem
);
    import bfa_pkg::*;

    localparam int CNT_W = $clog2(REG_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [REG_W-1:0] r_a, n_a;
    logic [REG_W-1:0] r_d, n_d;
    logic [REG_W:0]   r_rem, n_rem;
    logic [REG_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_d    = r_d;
        n_rem  = r_rem;
        trial  = {r_rem[REG_W-1:0], r_a[REG_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_dividend;
            n_d    = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_a   = r_a << 1;
            n_rem = (trial >= {1'b0, r_d}) ? trial - {1'b0, r_d} : trial;
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(REG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_d   <= n_d;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[REG_W-1:0];

endmodule

### rtl/bitmap_frame_allocator.sv
// Bitmap page-frame allocator, top level: usage map memory, request sequencer, APB registers.
// Depends on bfa_pkg and bfa_mod.
//
// One used/free bit per frame (1 = used) lives in a 1024 x 64 synchronous
// RAM. After reset the block writes the whole map to "used" and holds
// o_stall high meanwhile; APB writes are taken during that time. Requests
// are handled one at a time. Free and reserve read the map word at the
// accepting edge, then update the bit and write it back, then pass the
// result stage into the output register, after which the next request is
// taken. Allocate runs a next-fit scan that checks one map word per cycle,
// pipelined behind the registered RAM read: the result word comes when a
// free frame is found or when every map word to be checked has been checked
// (at most words-to-limit plus one wrap pass back to the start word).
// When the search pointer lies at or beyond frame_limit, a bit-serial
// remainder unit first folds it into range. Frames below low_reserved_frames
// are never handed out. A finished result waits in an output register; the
// next request is accepted once that register is free to take its result.
// Registers: 0x0 frame_limit (clamped to 65536 in use), 0x4
// low_reserved_frames; paddr[2] selects the register.
module bitmap_frame_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [bfa_pkg::FRAME_W-1:0] i_frame_index,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [bfa_pkg::FRAME_W-1:0] o_granted_frame,
    // APB register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfa_pkg::CFG_AW-1:0]  paddr,
    input  logic [bfa_pkg::APB_DW-1:0]  pwdata,
    output logic [bfa_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bfa_pkg::*;

    // usage map
    t_word               r_map [MAP_DEPTH];
    t_word               r_mem_q;
    logic                mem_we;
    logic [WORD_AW-1:0]  mem_waddr;
    logic [WORD_AW-1:0]  mem_raddr;
    t_word               mem_wdata;

    // control
    t_state              r_state, n_state;
    logic [WORD_AW-1:0]  r_clr_addr, n_clr_addr;
    logic [REG_W-1:0]    r_limit, n_limit;
    logic [REG_W-1:0]    r_lowres, n_lowres;
    logic [REG_W-1:0]    r_next, n_next;

    // request held while it runs
    t_req                r_req, n_req;
    logic [FRAME_W-1:0]  r_idx, n_idx;
    logic [FRAME_W-1:0]  r_cur, n_cur;
    logic [WORD_AW-1:0]  r_wlast, n_wlast;

    // scan: issue stage (read address) and check stage (read data)
    logic                r_iss, n_iss;
    logic [WORD_AW-1:0]  r_iw, n_iw;
    logic                r_ipass, n_ipass;
    logic                r_cv, n_cv;
    logic [WORD_AW-1:0]  r_cw, n_cw;
    logic                r_cpass, n_cpass;

    // result
    t_status             r_res_status, n_res_status;
    logic [FRAME_W-1:0]  r_res_granted, n_res_granted;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [FRAME_W-1:0]  r_out_granted, n_out_granted;

    // combinational helpers
    logic [REG_W-1:0]    eff_lim;
    logic [REG_W-1:0]    lim_m1;
    logic                idx_ok;
    logic                cfg_we;
    logic                start_scan;
    logic [FRAME_W-1:0]  start_cur;
    logic                load_out;
    t_word               scan_mask;
    t_word               free_bits;
    logic [FRAME_W-1:0]  found;
    t_word               bit_sel;
    logic                mod_start;
    logic                mod_done;
    logic [REG_W-1:0]    mod_rem;

    // pointer fold when it lies at or beyond the limit
    bfa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_next),
        .i_divisor  (eff_lim),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign eff_lim = (r_limit > REG_W'(NUM_FRAMES)) ? REG_W'(NUM_FRAMES) : r_limit;
    assign lim_m1  = eff_lim - REG_W'(1);
    assign idx_ok  = {1'b0, i_frame_index} < eff_lim;
    assign cfg_we  = psel && penable && pwrite;

    // Candidate frames of the word under check: inside the limit, above the
    // reserved low range, and on the first pass not below the start frame.
    assign scan_mask = word_ge_mask(r_cpass ? '0 : REG_W'(r_cur), r_cw)
                     & ~word_ge_mask(eff_lim, r_cw)
                     & word_ge_mask(r_lowres, r_cw);
    assign free_bits = ~r_mem_q & scan_mask;
    assign found     = {r_cw, low_index(free_bits)};

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_limit       = r_limit;
        n_lowres      = r_lowres;
        n_next        = r_next;
        n_req         = r_req;
        n_idx         = r_idx;
        n_cur         = r_cur;
        n_wlast       = r_wlast;
        n_iss         = r_iss;
        n_iw          = r_iw;
        n_ipass       = r_ipass;
        n_cv          = r_cv;
        n_cw          = r_cw;
        n_cpass       = r_cpass;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        mem_we        = 1'b0;
        mem_waddr     = r_cw;
        mem_wdata     = r_mem_q;
        mem_raddr     = r_iw;
        mod_start     = 1'b0;
        start_scan    = 1'b0;
        start_cur     = r_next[FRAME_W-1:0];
        load_out      = 1'b0;
        bit_sel       = t_word'(1) << r_idx[BIT_W-1:0];

        if (cfg_we) begin
            if (paddr[2] == CFG_IDX_LOWRES) begin
                n_lowres = pwdata[REG_W-1:0];
            end else begin
                n_limit = pwdata[REG_W-1:0];
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = {MAP_WORD_BITS{1'b1}};
                n_clr_addr = r_clr_addr + WORD_AW'(1);
                if (r_clr_addr == WORD_AW'(MAP_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // read the word of the named frame now; used by free/reserve
                mem_raddr = i_frame_index[FRAME_W-1:BIT_W];
                if (i_valid) begin
                    n_req         = t_req'(i_req_type);
                    n_idx         = i_frame_index;
                    n_res_granted = '0;
                    n_res_status  = ST_OK;
                    unique case (t_req'(i_req_type))
                        REQ_ALLOC: begin
                            n_wlast = lim_m1[FRAME_W-1:BIT_W];
                            if (eff_lim == '0) begin
                                n_res_status = ST_NOMEM;
                                n_state      = S_RESULT;
                            end else if (r_next < eff_lim) begin
                                start_scan = 1'b1;
                                start_cur  = r_next[FRAME_W-1:0];
                            end else begin
                                mod_start = 1'b1;
                                n_state   = S_MOD;
                            end
                        end
                        REQ_FREE, REQ_RESERVE: begin
                            if (idx_ok) begin
                                n_state = S_RMW;
                            end else begin
                                n_res_status = ST_RANGE;
                                n_state      = S_RESULT;
                            end
                        end
                        REQ_NONE: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    start_scan = 1'b1;
                    start_cur  = mod_rem[FRAME_W-1:0];
                end
            end
            S_SCAN: begin
                // issue stage
                if (r_iss) begin
                    mem_raddr = r_iw;
                    n_cv      = 1'b1;
                    n_cw      = r_iw;
                    n_cpass   = r_ipass;
                    if (!r_ipass && r_iw == r_wlast) begin
                        n_iw    = '0;
                        n_ipass = 1'b1;
                    end else if (r_ipass && r_iw == r_cur[FRAME_W-1:BIT_W]) begin
                        n_iss = 1'b0;
                    end else begin
                        n_iw = r_iw + WORD_AW'(1);
                    end
                end else begin
                    n_cv = 1'b0;
                end
                // check stage
                if (r_cv) begin
                    if (free_bits != '0) begin
                        mem_we        = 1'b1;
                        mem_waddr     = r_cw;
                        mem_wdata     = r_mem_q | (t_word'(1) << found[BIT_W-1:0]);
                        n_next        = REG_W'(found) + REG_W'(1);
                        n_res_status  = ST_OK;
                        n_res_granted = found;
                        n_state       = S_RESULT;
                    end else if (r_cpass && r_cw == r_cur[FRAME_W-1:BIT_W]) begin
                        n_res_status = ST_NOMEM;
                        n_state      = S_RESULT;
                    end
                end
            end
            S_RMW: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[FRAME_W-1:BIT_W];
                if (r_req == REQ_FREE) begin
                    mem_wdata    = r_mem_q & ~bit_sel;
                    n_res_status = ((r_mem_q & bit_sel) != '0) ? ST_OK : ST_DOUBLE;
                end else begin
                    mem_wdata    = r_mem_q | bit_sel;
                    n_res_status = ST_OK;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // scan start: first word of the first pass, check stage empty
        if (start_scan) begin
            n_cur   = start_cur;
            n_iss   = 1'b1;
            n_iw    = start_cur[FRAME_W-1:BIT_W];
            n_ipass = 1'b0;
            n_cv    = 1'b0;
            n_state = S_SCAN;
        end

        // output register
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_valid   = r_out_valid && i_stall;
        if (load_out) begin
            n_out_valid   = 1'b1;
            n_out_status  = r_res_status;
            n_out_granted = r_res_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_limit     <= '0;
            r_lowres    <= REG_W'(LOW_RES_RESET);
            r_next      <= '0;
            r_iss       <= 1'b0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_limit     <= n_limit;
            r_lowres    <= n_lowres;
            r_next      <= n_next;
            r_iss       <= n_iss;
            r_cv        <= n_cv;
            r_out_valid <= n_out_valid;
        end
        r_req         <= n_req;
        r_idx         <= n_idx;
        r_cur         <= n_cur;
        r_wlast       <= n_wlast;
        r_iw          <= n_iw;
        r_ipass       <= n_ipass;
        r_cw          <= n_cw;
        r_cpass       <= n_cpass;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
    end

    // map RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_map[mem_raddr];
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_frame = r_out_granted;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == CFG_IDX_LOWRES) ? APB_DW'(r_lowres)
                                                          : APB_DW'(r_limit);

endmodule

### rtl/bfa_checker.sv
// Port-level checks of the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_frame_allocator.
module bfa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [1:0]                  o_status,
    input logic [bfa_pkg::FRAME_W-1:0] o_granted_frame,
    input logic                        pready
);
    import bfa_pkg::*;

    // a word held back by the sink stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_granted_frame))
        else $error("result word changed while stalled");

    // only a successful allocate names a frame
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_granted_frame == '0)
        else $error("granted frame nonzero on failed request");

    // one request at a time: input closes right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request accepted back to back");

    // reset empties the output and starts the map clear
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("output or input open right after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_granted_frame (o_granted_frame),
    .pready          (pready)
);

### tb/sv/bitmap_frame_allocator_checker.sv
`timescale 1ns / 100ps
// Checker for the bitmap frame allocator: watches the request, result and APB ports,
// predicts each result word and compares it with what the block returns.
// Depends on bfa_pkg for widths, request and status codes.
module bitmap_frame_allocator_checker
    import bfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  logic [1:0]         i_req_type,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [1:0]         i_status,
    input  logic [FRAME_W-1:0] i_granted_frame,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [CFG_AW-1:0]  i_paddr,
    input  logic [APB_DW-1:0]  i_pwdata,
    output int                 o_fail_count,
    output int                 o_answers_outstanding
);

    typedef struct packed {
        t_status            status;
        logic [FRAME_W-1:0] frame;
    } t_answer;

    // private copy of the usage map, 1 = used
    bit               frame_used [NUM_FRAMES];
    logic [REG_W-1:0] search_ptr;
    logic [REG_W-1:0] limit_reg;
    logic [REG_W-1:0] low_res_reg;
    t_answer          answers_due [$];
    t_answer          want;

    function automatic t_answer allocator_answer(input t_req r, input logic [FRAME_W-1:0] f);
        int      lim;
        int      cur;
        int      i;
        bit      found;
        t_answer a;
        lim = (limit_reg > NUM_FRAMES) ? NUM_FRAMES : int'(limit_reg);
        a.status = ST_OK;
        a.frame  = '0;
        found    = 1'b0;
        case (r)
            REQ_ALLOC: begin
                a.status = ST_NOMEM;
                if (lim != 0) begin
                    // next fit: start at the pointer folded into range
                    cur = int'(search_ptr) % lim;
                    for (i = 0; i < lim && !found; i++) begin
                        if (cur >= int'(low_res_reg) && !frame_used[cur]) begin
                            frame_used[cur] = 1'b1;
                            search_ptr      = REG_W'(cur + 1);
                            a.frame         = FRAME_W'(cur);
                            a.status        = ST_OK;
                            found           = 1'b1;
                        end else begin
                            cur++;
                            if (cur >= lim) cur = 0;
                        end
                    end
                end
            end
            REQ_FREE: begin
                if (int'(f) >= lim) begin
                    a.status = ST_RANGE;
                end else begin
                    if (!frame_used[f]) a.status = ST_DOUBLE;
                    frame_used[f] = 1'b0;
                end
            end
            REQ_RESERVE: begin
                if (int'(f) >= lim) a.status = ST_RANGE;
                else frame_used[f] = 1'b1;
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FRAMES; k++) frame_used[k] = 1'b1;
            search_ptr  = '0;
            limit_reg   = '0;
            low_res_reg = REG_W'(LOW_RES_RESET);
            answers_due.delete();
            o_fail_count          = 0;
            o_answers_outstanding = 0;
        end else begin
            // result first: it can never belong to a request taken at this edge
            if (i_res_valid && !i_res_stall) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result word, status %0d frame %0d",
                             $time, i_status, i_granted_frame);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_granted_frame !== want.frame) begin
                        $display("%0t: granted_frame mismatch, expected %0d actual %0d",
                                 $time, want.frame, i_granted_frame);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                answers_due.push_back(allocator_answer(t_req'(i_req_type), i_frame_index));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == CFG_IDX_LIMIT) limit_reg = i_pwdata[REG_W-1:0];
                else low_res_reg = i_pwdata[REG_W-1:0];
            end
            o_answers_outstanding = answers_due.size();
        end
    end

endmodule

### tb/sv/bitmap_frame_allocator_tb.sv
`timescale 1ns / 100ps
// Top of the bitmap frame allocator testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on bfa_pkg, bitmap_frame_allocator and bitmap_frame_allocator_checker.
module bitmap_frame_allocator_tb;
    import bfa_pkg::*;

    // longest legal quiet stretch: clearing pass (1024 words), a full wrap scan
    // (up to 1025 words) plus pointer fold, times a generous margin
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES   = 8;

    // byte addresses: register select sits in paddr[2]
    localparam logic [CFG_AW-1:0] ADDR_LIMIT  = {CFG_IDX_LIMIT, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_LOWRES = {CFG_IDX_LOWRES, 2'b00};

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [1:0]         i_req_type    = '0;
    logic [FRAME_W-1:0] i_frame_index = '0;
    logic               i_stall       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [CFG_AW-1:0]  paddr         = '0;
    logic [APB_DW-1:0]  pwdata        = '0;

    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [FRAME_W-1:0] o_granted_frame;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int gap_pct     = 0;    // chance in 100 that the sender idles a cycle
    int stall_pct   = 0;    // chance in 100 that the receiver stalls a cycle
    int quiet_cycles = 0;
    int fail_count;
    int answers_outstanding;

    bitmap_frame_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_frame_index   (i_frame_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_granted_frame (o_granted_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    bitmap_frame_allocator_checker checker_inst (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_req_valid           (i_valid),
        .i_req_stall           (o_stall),
        .i_req_type            (i_req_type),
        .i_frame_index         (i_frame_index),
        .i_res_valid           (o_valid),
        .i_res_stall           (i_stall),
        .i_status              (o_status),
        .i_granted_frame       (o_granted_frame),
        .i_psel                (psel),
        .i_penable             (penable),
        .i_pwrite              (pwrite),
        .i_pready              (pready),
        .i_paddr               (paddr),
        .i_pwdata              (pwdata),
        .o_fail_count          (fail_count),
        .o_answers_outstanding (answers_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random stall, one decision per edge
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: any accepted word on either channel resets the count
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, answers_outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // APB write: setup phase, access phase, then an idle phase with psel low so that
    // back-to-back writes never touch psel twice in one step
    task automatic reg_write(input logic [CFG_AW-1:0] a, input logic [REG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender holds off until every predicted result has come back
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (answers_outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [REG_W-1:0] lim, input logic [REG_W-1:0] low);
        settle();
        reg_write(ADDR_LIMIT, lim);
        reg_write(ADDR_LOWRES, low);
    endtask

    // Present one request word and return at the edge that accepts it.
    // valid only drops when a gap is taken, so it never toggles within a step.
    task automatic send(input t_req r, input logic [FRAME_W-1:0] f);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid       <= 1'b1;
        i_req_type    <= r;
        i_frame_index <= f;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    task automatic set_pace(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 86; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 86; end
            default: begin gap_pct = 26; stall_pct = 26; end
        endcase
    endtask

    // Mostly frees, allocs and reserves inside the managed range (biased
    // toward the allocatable part so allocs find frames), some just past the
    // limit, and a tenth pure noise with any request type and full-width index.
    task automatic send_random(input int lim_eff, input int low);
        int                 pick;
        int                 lo;
        t_req               r;
        logic [FRAME_W-1:0] f;
        pick = $urandom_range(99);
        if (pick < 10 || lim_eff == 0) begin
            r = t_req'($urandom_range(3));
            f = FRAME_W'($urandom());
        end else begin
            if (pick < 50) r = REQ_FREE;
            else if (pick < 85) r = REQ_ALLOC;
            else r = REQ_RESERVE;
            lo = (low < lim_eff) ? low : 0;
            if ($urandom_range(1) == 1) f = FRAME_W'($urandom_range(lim_eff - 1, lo));
            else f = FRAME_W'($urandom_range(lim_eff - 1));
            if ($urandom_range(19) == 0) f = FRAME_W'(lim_eff + $urandom_range(3));
        end
        send(r, f);
    endtask

    initial begin
        int lim;
        int low;
        int lim_eff;
        int count;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // reset settings, limit zero: nothing in range, nothing to hand out
        send(REQ_ALLOC, '0);
        send(REQ_FREE, '0);
        send(REQ_RESERVE, '1);
        send(REQ_NONE, '1);

        // limit above the store acts as the whole store; no low reservation
        configure(17'h1FFFF, '0);
        send(REQ_FREE, '1);          // top frame, was used
        send(REQ_FREE, '1);          // double free
        send(REQ_FREE, '0);
        send(REQ_ALLOC, '0);         // grants frame 0
        send(REQ_ALLOC, '1);         // scans the long way up to the top frame, pointer = 0x10000
        send(REQ_RESERVE, 16'd5);    // already used, stays used
        send(REQ_FREE, 16'd5);
        send(REQ_RESERVE, 16'd5);

        // pointer now beyond the limit; low frames reserved
        configure(17'd300, 17'd256);
        send(REQ_FREE, 16'd260);
        send(REQ_FREE, 16'd10);
        send(REQ_ALLOC, '0);         // skips frame 10, takes 260
        send(REQ_ALLOC, '0);         // only a reserved-low frame is free: out of memory
        send(REQ_RESERVE, 16'd299);
        send(REQ_RESERVE, 16'd300);  // at the limit: range error
        send(REQ_FREE, 16'd300);

        // single-frame map
        configure(17'd1, '0);
        send(REQ_FREE, '0);
        send(REQ_ALLOC, '0);
        send(REQ_ALLOC, '0);

        // reservation covers the whole store: full scan, out of memory
        configure(17'h10000, 17'h10000);
        send(REQ_FREE, 16'd1000);
        send(REQ_ALLOC, '0);

        // --- random part, one register setting per phase ---
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin lim = 64;    low = 0;   end
                1: begin lim = 700;   low = 256; end
                2: begin lim = 65536; low = 256; end
                3: begin
                    lim = $urandom_range(2048, 2);
                    low = $urandom_range(lim);
                end
                4: begin lim = 0;     low = 0;   end
                5: begin lim = 1000;  low = 999; end
                6: begin lim = 17'h1FFFF; low = 60000; end
                default: begin
                    lim = $urandom_range(600, 1);
                    low = 0;
                end
            endcase
            configure(REG_W'(lim), REG_W'(low));
            lim_eff = (lim > NUM_FRAMES) ? NUM_FRAMES : lim;
            // a zero limit only yields error answers; keep that phase short
            count = (lim_eff == 0) ? 30 : ITEMS_PER_PHASE;
            for (int k = 0; k < count; k++) begin
                if (k % 25 == 0) set_pace((phase + k / 25) % 4);
                send_random(lim_eff, low);
            end
        end

        // drain, then let any stray word show up
        settle();
        set_pace(0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && answers_outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
